// ----- rtl/core/fbs_pkg.sv -----
// Shared types and constants for the frame brightness score block.
// Used by the channel interfaces, the shared MAC, the divider and the top level.
// No dependencies.

package fbs_pkg;

  // Payload widths
  localparam int CH_W    = 8;   // one color component
  localparam int SCORE_W = 8;   // frame score
  localparam int COEF_W  = 8;   // second operand of the shared MAC

  // Configuration port geometry
  localparam int CFG_W   = 13;  // frame_width and frame_height registers
  localparam int APB_AW  = 3;   // two 32-bit registers at byte addresses 0 and 4
  localparam int APB_DW  = 32;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic clear;  // start a new sum with this product
    logic en;     // add one product this cycle
  } mac_ctl_t;

  // Status of the iterative divider
  typedef struct packed {
    logic busy;   // iterations in flight
    logic done;   // quotient valid, one-cycle pulse
  } div_stat_t;

endpackage

// ----- rtl/core/fbs_if.sv -----
// Valid/ready channel interfaces of the frame brightness score block:
// one pixel transaction in, one score transaction out.
// Depends on fbs_pkg for the payload widths.

interface fbs_pix_if;
  import fbs_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface fbs_score_if;
  import fbs_pkg::*;

  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;

  modport source (output valid, output score, input ready);
  modport sink   (input valid, input score, output ready);
endinterface

// ----- rtl/core/fbs_mac.sv -----
// Shared multiply-accumulate unit: one product of an operand and an
// 8-bit coefficient per cycle, summed into a registered accumulator.
// Depends on fbs_pkg (mac_ctl_t, COEF_W).

module fbs_mac #(
  parameter int A_W   = 20,
  parameter int ACC_W = 28
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fbs_pkg::mac_ctl_t        ctl_i,
  input  logic [A_W-1:0]           a_i,
  input  logic [fbs_pkg::COEF_W-1:0] b_i,
  output logic [ACC_W-1:0]         acc_o
);
  import fbs_pkg::*;

  logic [A_W+COEF_W-1:0] prod;
  logic [ACC_W-1:0]      acc_q, acc_d;

  // Form one product and add it to the running sum, or restart the sum
  always_comb begin
    prod  = a_i * b_i;
    acc_d = acc_q;
    if (ctl_i.en) begin
      acc_d = (ctl_i.clear ? '0 : acc_q) + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- rtl/core/fbs_div.sv -----
// Restoring divider: one quotient bit per cycle; done pulses for a single cycle
// together with the last quotient bit in the quotient register.
// Depends on fbs_pkg (div_stat_t).

module fbs_div #(
  parameter int DVD_W = 27,
  parameter int DSR_W = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DVD_W-1:0]   dividend_i,
  input  logic [DSR_W-1:0]   divisor_i,
  output logic [DVD_W-1:0]   quotient_o,
  output fbs_pkg::div_stat_t stat_o
);
  import fbs_pkg::*;

  localparam int ITER_W = $clog2(DVD_W + 1);

  logic [DSR_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DSR_W:0]    trial;
  logic              fits;

  // Shift one dividend bit into the remainder and try the subtraction;
  // quotient bits replace dividend bits from the bottom of dvd_q
  always_comb begin
    trial  = {rem_q, dvd_q[DVD_W-1]};
    fits   = trial >= {1'b0, divisor_i};
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    iter_d = iter_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      rem_d  = '0;
      dvd_d  = dividend_i;
      iter_d = ITER_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? DSR_W'(trial - {1'b0, divisor_i}) : trial[DSR_W-1:0];
      dvd_d  = {dvd_q[DVD_W-2:0], fits};
      iter_d = iter_q - ITER_W'(1);
      if (iter_q == ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      iter_q <= iter_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers hold no control meaning
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign quotient_o  = dvd_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ----- rtl/core/frame_brightness_score.sv -----
// Frame brightness score. Pixels enter one per transaction in raster order; the frame size
// comes from the frame_width (0x0) and frame_height (0x4) registers, where zero reads as one
// and values above MAX_DIMENSION read as MAX_DIMENSION. A pixel off the sampling grid leaves
// the block idle and ready. A pixel on the grid holds ready low while the shared
// multiply-accumulate unit forms the luma from the three components, one at a time, and then
// the counters update. The last pixel of a frame adds two passes, each a product on the MAC
// and a restoring divide, and then issues the score transaction. The score sits in an output
// register, so the next frame's pixels flow while it waits; the block stalls only if a
// second score is ready first.
// Depends on fbs_pkg, fbs_if, fbs_mac and fbs_div.

module frame_brightness_score #(
  parameter int MAX_DIMENSION = 4096,
  parameter int SAMPLE_GRID   = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  fbs_pix_if.sink                    pix_i,
  fbs_score_if.source                score_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fbs_pkg::APB_AW-1:0] paddr,
  input  logic [fbs_pkg::APB_DW-1:0] pwdata,
  output logic [fbs_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import fbs_pkg::*;

  // Geometry derived from the parameters
  localparam int POS_W    = $clog2(MAX_DIMENSION);
  localparam int DIM_W    = $clog2(MAX_DIMENSION + 1);
  localparam int STEP_MAX = (MAX_DIMENSION / SAMPLE_GRID > 1) ? MAX_DIMENSION / SAMPLE_GRID : 2;
  localparam int SKIP_W   = $clog2(STEP_MAX);
  localparam int N_W      = SKIP_W + 1;
  localparam int PRD_W    = N_W + $clog2(SAMPLE_GRID + 1);
  localparam int CMP_A    = (PRD_W > DIM_W) ? PRD_W : DIM_W;
  localparam int CMP_W    = (CMP_A > CFG_W) ? CMP_A : CFG_W;
  localparam int CNT_W    = POS_W + $clog2(SAMPLE_GRID) + 2;
  localparam int WEIGHT_W = 7;
  localparam int ACC_W    = CNT_W + COEF_W;
  localparam int DVD_W    = CNT_W + WEIGHT_W;

  // Luma and scoring constants
  localparam logic [COEF_W-1:0] COEF_RED      = 8'd54;
  localparam logic [COEF_W-1:0] COEF_GREEN    = 8'd183;
  localparam logic [COEF_W-1:0] COEF_BLUE     = 8'd19;
  localparam logic [COEF_W-1:0] WEIGHT_BRIGHT = 8'd100;
  localparam logic [COEF_W-1:0] WEIGHT_VARIED = 8'd30;
  localparam logic [CH_W-1:0]   BRIGHT_LIMIT  = 8'd24;
  localparam logic [CH_W-1:0]   VARIED_LIMIT  = 8'd8;
  localparam int                LUMA_SHIFT    = 8;
  localparam logic [CFG_W-1:0]  DIM_RESET     = 13'd64;

  typedef enum logic {REG_WIDTH, REG_HEIGHT} reg_idx_e;
  typedef enum logic [1:0] {CH_RED, CH_GREEN, CH_BLUE} chan_e;
  typedef enum logic [2:0] {
    S_IDLE, S_LUMA, S_UPDATE, S_PROD, S_DIVS, S_DIVW, S_EMIT
  } state_e;

  // Configuration registers
  logic [CFG_W-1:0] cfg_width_q, cfg_height_q;
  logic             cfg_wr;

  // Sequencer and frame state
  state_e             state_q, state_d;
  chan_e              chan_q, chan_d;
  logic               term_q, term_d;      // 0: bright term, 1: varied term
  logic               end_q, end_d;
  logic [POS_W-1:0]   col_pos_q, col_pos_d, row_pos_q, row_pos_d;
  logic [SKIP_W-1:0]  col_skip_q, col_skip_d, row_skip_q, row_skip_d;
  logic [CNT_W-1:0]   samples_q, samples_d, bright_q, bright_d, varied_q, varied_d;
  logic [CH_W-1:0]    prev_luma_q, prev_luma_d;
  logic               prev_valid_q, prev_valid_d;
  logic               out_valid_q, out_valid_d;
  logic [SCORE_W-1:0] score_acc_q, score_acc_d;
  logic [SCORE_W-1:0] out_score_q, out_score_d;
  logic [CH_W-1:0]    red_q, green_q, blue_q;

  // Decoded geometry for the current position
  logic [DIM_W-1:0]  w_eff, h_eff;
  logic              col_last, row_last, col_wrap, row_wrap;
  logic              pix_fire;
  logic [CH_W-1:0]   luma, luma_diff;

  // Shared units
  mac_ctl_t          mac_ctl;
  logic [CNT_W-1:0]  mac_a;
  logic [COEF_W-1:0] mac_b;
  logic [ACC_W-1:0]  mac_acc;
  logic              div_start;
  logic [CNT_W-1:0]  div_divisor;
  logic [DVD_W-1:0]  div_quot;
  div_stat_t         div_stat;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] vx;
    begin
      vx = CMP_W'(v);
      if (vx == '0) begin
        clamp_dim = DIM_W'(1);
      end else if (vx > CMP_W'(MAX_DIMENSION)) begin
        clamp_dim = DIM_W'(MAX_DIMENSION);
      end else begin
        clamp_dim = DIM_W'(vx);
      end
    end
  endfunction

  function automatic logic at_last(input logic [POS_W-1:0] pos, input logic [DIM_W-1:0] dim);
    begin
      at_last = CMP_W'(pos) >= (CMP_W'(dim) - CMP_W'(1));
    end
  endfunction

  // skip+1 reaches the step dim/SAMPLE_GRID exactly when (skip+2)*SAMPLE_GRID exceeds dim
  function automatic logic skip_wraps(input logic [SKIP_W-1:0] skip,
                                      input logic [DIM_W-1:0] dim);
    logic [N_W-1:0]   n1;
    logic [PRD_W-1:0] prd;
    begin
      n1  = N_W'(skip) + N_W'(2);
      prd = PRD_W'(n1) * PRD_W'(SAMPLE_GRID);
      skip_wraps = (CMP_W'(dim) <= CMP_W'(SAMPLE_GRID)) || (CMP_W'(prd) > CMP_W'(dim));
    end
  endfunction

  // Register write and read-back
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= DIM_RESET;
      cfg_height_q <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_WIDTH:  cfg_width_q  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: cfg_height_q <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_WIDTH:  prdata = APB_DW'(cfg_width_q);
      REG_HEIGHT: prdata = APB_DW'(cfg_height_q);
    endcase
  end

  // Position decode
  assign w_eff    = clamp_dim(cfg_width_q);
  assign h_eff    = clamp_dim(cfg_height_q);
  assign col_last = at_last(col_pos_q, w_eff);
  assign row_last = at_last(row_pos_q, h_eff);
  assign col_wrap = skip_wraps(col_skip_q, w_eff);
  assign row_wrap = skip_wraps(row_skip_q, h_eff);

  assign pix_i.ready = (state_q == S_IDLE);
  assign pix_fire    = pix_i.valid && pix_i.ready;

  assign luma      = mac_acc[LUMA_SHIFT +: CH_W];
  assign luma_diff = (luma > prev_luma_q) ? luma - prev_luma_q : prev_luma_q - luma;

  assign div_divisor = (samples_q == '0) ? CNT_W'(1) : samples_q;

  // Sequencer: next state, counters and shared unit control
  always_comb begin
    state_d      = state_q;
    chan_d       = chan_q;
    term_d       = term_q;
    end_d        = end_q;
    col_pos_d    = col_pos_q;
    row_pos_d    = row_pos_q;
    col_skip_d   = col_skip_q;
    row_skip_d   = row_skip_q;
    samples_d    = samples_q;
    bright_d     = bright_q;
    varied_d     = varied_q;
    prev_luma_d  = prev_luma_q;
    prev_valid_d = prev_valid_q;
    score_acc_d  = score_acc_q;
    out_score_d  = out_score_q;
    out_valid_d  = out_valid_q && !score_o.ready;
    mac_ctl      = '0;
    mac_a        = '0;
    mac_b        = '0;
    div_start    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (pix_fire) begin
          end_d = col_last && row_last;
          // Advance the raster position; the frame end returns it to the origin
          if (col_last && row_last) begin
            col_pos_d  = '0;
            row_pos_d  = '0;
            col_skip_d = '0;
            row_skip_d = '0;
          end else if (col_last) begin
            col_pos_d  = '0;
            col_skip_d = '0;
            row_pos_d  = row_pos_q + POS_W'(1);
            row_skip_d = row_wrap ? '0 : row_skip_q + SKIP_W'(1);
          end else begin
            col_pos_d  = col_pos_q + POS_W'(1);
            col_skip_d = col_wrap ? '0 : col_skip_q + SKIP_W'(1);
          end
          if (col_skip_q == '0 && row_skip_q == '0) begin
            chan_d  = CH_RED;
            state_d = S_LUMA;
          end else if (col_last && row_last) begin
            term_d  = 1'b0;
            state_d = S_PROD;
          end
        end
      end

      // One weighted component per cycle into the MAC
      S_LUMA: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.clear = (chan_q == CH_RED);
        unique case (chan_q)
          CH_RED: begin
            mac_a  = CNT_W'(red_q);
            mac_b  = COEF_RED;
            chan_d = CH_GREEN;
          end
          CH_GREEN: begin
            mac_a  = CNT_W'(green_q);
            mac_b  = COEF_GREEN;
            chan_d = CH_BLUE;
          end
          default: begin
            mac_a   = CNT_W'(blue_q);
            mac_b   = COEF_BLUE;
            state_d = S_UPDATE;
          end
        endcase
      end

      // Count the sample and compare against the previous one
      S_UPDATE: begin
        samples_d = samples_q + CNT_W'(1);
        if (luma > BRIGHT_LIMIT) begin
          bright_d = bright_q + CNT_W'(1);
        end
        if (prev_valid_q && luma_diff > VARIED_LIMIT) begin
          varied_d = varied_q + CNT_W'(1);
        end
        prev_luma_d  = luma;
        prev_valid_d = 1'b1;
        term_d       = 1'b0;
        state_d      = end_q ? S_PROD : S_IDLE;
      end

      // Weight the count of the current term
      S_PROD: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_a         = term_q ? varied_q : bright_q;
        mac_b         = term_q ? WEIGHT_VARIED : WEIGHT_BRIGHT;
        state_d       = S_DIVS;
      end

      S_DIVS: begin
        if (!div_stat.busy) begin
          div_start = 1'b1;
          state_d   = S_DIVW;
        end
      end

      // Sum the truncated quotients modulo the score width
      S_DIVW: begin
        if (div_stat.done) begin
          score_acc_d = (term_q ? score_acc_q : '0) + div_quot[SCORE_W-1:0];
          if (term_q) begin
            state_d = S_EMIT;
          end else begin
            term_d  = 1'b1;
            state_d = S_PROD;
          end
        end
      end

      // Hand the score to the output register and start a new frame
      S_EMIT: begin
        if (!out_valid_q || score_o.ready) begin
          out_valid_d  = 1'b1;
          out_score_d  = score_acc_q;
          samples_d    = '0;
          bright_d     = '0;
          varied_d     = '0;
          prev_luma_d  = '0;
          prev_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      chan_q       <= CH_RED;
      term_q       <= 1'b0;
      end_q        <= 1'b0;
      col_pos_q    <= '0;
      row_pos_q    <= '0;
      col_skip_q   <= '0;
      row_skip_q   <= '0;
      samples_q    <= '0;
      bright_q     <= '0;
      varied_q     <= '0;
      prev_luma_q  <= '0;
      prev_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      chan_q       <= chan_d;
      term_q       <= term_d;
      end_q        <= end_d;
      col_pos_q    <= col_pos_d;
      row_pos_q    <= row_pos_d;
      col_skip_q   <= col_skip_d;
      row_skip_q   <= row_skip_d;
      samples_q    <= samples_d;
      bright_q     <= bright_d;
      varied_q     <= varied_d;
      prev_luma_q  <= prev_luma_d;
      prev_valid_q <= prev_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers: pixel capture, score sum, output score
  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      red_q   <= pix_i.red;
      green_q <= pix_i.green;
      blue_q  <= pix_i.blue;
    end
    score_acc_q <= score_acc_d;
    out_score_q <= out_score_d;
  end

  assign score_o.valid = out_valid_q;
  assign score_o.score = out_score_q;

  fbs_mac #(
    .A_W   (CNT_W),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (mac_acc)
  );

  fbs_div #(
    .DVD_W (DVD_W),
    .DSR_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mac_acc[DVD_W-1:0]),
    .divisor_i  (div_divisor),
    .quotient_o (div_quot),
    .stat_o     (div_stat)
  );

endmodule

// ----- tb/fbs_score_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for frame_brightness_score: follows register writes and pixel
// transactions, predicts each frame score and compares the score transactions.
// Depends on fbs_pkg and the channel interfaces of fbs_if.

module fbs_score_checker #(
  parameter int                        MAX_DIMENSION = 4096,
  parameter int                        SAMPLE_GRID   = 64,
  parameter logic [fbs_pkg::APB_AW-1:0] WIDTH_ADDR   = '0,
  parameter logic [fbs_pkg::APB_AW-1:0] HEIGHT_ADDR  = '0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  fbs_pix_if                         pix_i,
  fbs_score_if                       score_i,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [fbs_pkg::APB_AW-1:0] paddr,
  input  logic [fbs_pkg::APB_DW-1:0] pwdata,
  output int                         fail_count_o,
  output int                         scores_due_o,
  output int                         pixels_left_o
);
  import fbs_pkg::*;

  // Shadow of the registers and of the frame state
  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  logic [11:0]        col_pos;
  logic [11:0]        row_pos;
  logic [5:0]         col_skip;
  logic [5:0]         row_skip;
  logic [13:0]        samples;
  logic [13:0]        bright;
  logic [13:0]        varied;
  logic [7:0]         last_luma;
  logic               have_last;
  logic [SCORE_W-1:0] due_scores[$];

  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIMENSION) return MAX_DIMENSION;
    return 32'(v);
  endfunction

  function automatic int unsigned grid_step(input int unsigned dim);
    return (dim > SAMPLE_GRID) ? dim / SAMPLE_GRID : 1;
  endfunction

  function automatic logic [5:0] skip_after(input logic [5:0] skip, input int unsigned step);
    int unsigned n;
    n = skip + 1;
    return (n >= step) ? 6'd0 : 6'(n);
  endfunction

  task clear_frame();
    col_pos   = '0;
    row_pos   = '0;
    col_skip  = '0;
    row_skip  = '0;
    samples   = '0;
    bright    = '0;
    varied    = '0;
    last_luma = '0;
    have_last = 1'b0;
  endtask

  task report(input string msg);
    fail_count_o++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  // Advance the frame by one pixel; queue the score when it closes the frame
  task account_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                     input logic [CH_W-1:0] b);
    int unsigned w, h, luma, luma_delta, denom, score;
    logic        last_col, last_row;
    w        = eff_dim(width_reg);
    h        = eff_dim(height_reg);
    last_col = col_pos >= w - 1;
    last_row = row_pos >= h - 1;
    if (col_skip == 0 && row_skip == 0) begin
      luma = (54 * 32'(r) + 183 * 32'(g) + 19 * 32'(b)) >> 8;
      if (luma > 24) bright++;
      luma_delta = (luma > last_luma) ? luma - last_luma : last_luma - luma;
      if (have_last && luma_delta > 8) varied++;
      last_luma = 8'(luma);
      have_last = 1'b1;
      samples++;
    end
    if (last_col && last_row) begin
      denom = (samples == 0) ? 1 : samples;
      score = 32'(bright) * 100 / denom + 32'(varied) * 30 / denom;
      due_scores.push_back(SCORE_W'(score));
      clear_frame();
    end else if (last_col) begin
      col_pos  = '0;
      col_skip = '0;
      row_pos  = row_pos + 1'b1;
      row_skip = skip_after(row_skip, grid_step(h));
    end else begin
      col_pos  = col_pos + 1'b1;
      col_skip = skip_after(col_skip, grid_step(w));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned w, h, in_row;
    if (!rst_ni) begin
      width_reg  = 13'd64;
      height_reg = 13'd64;
      clear_frame();
      due_scores.delete();
    end else begin
      // Register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr == WIDTH_ADDR) width_reg = pwdata[CFG_W-1:0];
        else if (paddr == HEIGHT_ADDR) height_reg = pwdata[CFG_W-1:0];
      end
      // Compare the score transaction with the oldest frame
      if (score_i.valid && score_i.ready) begin
        if (due_scores.size() == 0) begin
          report($sformatf("score %0d with no frame pending", score_i.score));
        end else begin
          if (score_i.score !== due_scores[0])
            report($sformatf("score mismatch: got %0d, expected %0d",
                             score_i.score, due_scores[0]));
          void'(due_scores.pop_front());
        end
      end
      // Predict from the pixel transaction
      if (pix_i.valid && pix_i.ready) account_pixel(pix_i.red, pix_i.green, pix_i.blue);
    end
    // Pixels still needed to close the current frame
    w             = eff_dim(width_reg);
    h             = eff_dim(height_reg);
    in_row        = (col_pos >= w - 1) ? 1 : w - col_pos;
    pixels_left_o = (row_pos >= h - 1) ? in_row : in_row + (h - 1 - row_pos) * w;
    scores_due_o  = due_scores.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for frame_brightness_score: clock, reset, register writes,
// pixel stimulus, score receiver and the verdict.
// Depends on fbs_pkg, fbs_if, the block itself and fbs_score_checker.

module tb_top;
  import fbs_pkg::*;

  localparam logic [APB_AW-1:0] REG_FRAME_WIDTH  = 3'h0;
  localparam logic [APB_AW-1:0] REG_FRAME_HEIGHT = 3'h4;
  localparam int                CYCLE_LIMIT      = 1000000;
  localparam int                HOLD_CYCLES      = 400;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  logic        hold_req  = 1'b0;
  int          hold_left = 0;
  int          cycle_count = 0;
  logic [7:0]  walk_level = 8'd40;
  int          fail_count;
  int          scores_due;
  int          pixels_left;

  // Gray levels around the brightness and variation thresholds, pure colors
  logic [23:0] probe_pixels [18] = '{
    24'h000000, 24'hFFFFFF, 24'h181818, 24'h191919, 24'h212121, 24'h2A2A2A,
    24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF, 24'h000000, 24'h101010,
    24'h080808, 24'h111111, 24'h000000, 24'h090909, 24'h010101, 24'h191919
  };

  fbs_pix_if   pix_if ();
  fbs_score_if score_if ();

  frame_brightness_score DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_if),
    .score_o (score_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fbs_score_checker #(
    .WIDTH_ADDR  (REG_FRAME_WIDTH),
    .HEIGHT_ADDR (REG_FRAME_HEIGHT)
  ) score_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_i         (pix_if),
    .score_i       (score_if),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count_o  (fail_count),
    .scores_due_o  (scores_due),
    .pixels_left_o (pixels_left)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Score receiver: random stalls, plus one long hold-off on request
  initial begin
    score_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        score_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_left = HOLD_CYCLES;
        score_if.ready <= 1'b0;
      end else begin
        score_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Setup and access cycle, then the bus returns to idle
  task reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task set_size(input int unsigned w, input int unsigned h);
    reg_write(REG_FRAME_WIDTH, APB_DW'(w));
    reg_write(REG_FRAME_HEIGHT, APB_DW'(h));
  endtask

  // Drop valid and hold until every score is out and the block has settled
  task wait_idle();
    pix_if.valid <= 1'b0;
    @(negedge clk_i);
    while (scores_due != 0) @(negedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task frame_remaining(output int n);
    pix_if.valid <= 1'b0;
    @(negedge clk_i);
    n = pixels_left;
    @(posedge clk_i);
  endtask

  // Offer one pixel after a random gap and hold it until accepted
  task send_pixel(input logic [23:0] px);
    while ($urandom_range(0, 99) < idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    {pix_if.red, pix_if.green, pix_if.blue} <= px;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
  endtask

  function automatic logic [23:0] next_pixel();
    int         t;
    logic [7:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: return 24'($urandom());
      3, 4, 5: begin
        // gray walk, steps straddle the variation threshold
        t = int'(walk_level) + int'($urandom_range(0, 24)) - 12;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        walk_level = 8'(t);
        return {3{walk_level}};
      end
      6, 7: begin
        v = 8'($urandom_range(18, 32));
        return {3{v}};
      end
      8: return {($urandom_range(0, 1) ? 8'hFF : 8'h00), ($urandom_range(0, 1) ? 8'hFF : 8'h00),
                 ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
      default: begin
        v = 8'($urandom());
        return {3{v}};
      end
    endcase
  endfunction

  task send_pixels(input int n);
    repeat (n) send_pixel(next_pixel());
  endtask

  task run_frame(input int unsigned w, input int unsigned h);
    int n;
    wait_idle();
    set_size(w, h);
    frame_remaining(n);
    send_pixels(n);
  endtask

  // Start a frame, then shrink it to one pixel so the next pixel closes it
  task run_partial(input int unsigned w, input int unsigned h, input int count);
    int n;
    wait_idle();
    set_size(w, h);
    send_pixels(count);
    wait_idle();
    set_size(1, 1);
    frame_remaining(n);
    send_pixels(n);
  endtask

  // Mostly small frames, some with column or row sampling, some zero sizes
  task random_size();
    int unsigned w, h;
    int          kind;
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 4);
    end else if (kind == 14) begin
      w = $urandom_range(65, 160);
      h = 1;
    end else if (kind == 15) begin
      w = 1;
      h = $urandom_range(65, 160);
    end else if (kind == 16) begin
      w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
      h = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
    end else if (kind == 17) begin
      w = $urandom_range(9, 30);
      h = $urandom_range(1, 3);
    end else begin
      w = $urandom_range(1, 2);
      h = $urandom_range(1, 2);
    end
    set_size(w, h);
  endtask

  initial begin
    int n, part, random_pixels, random_frames;
    pix_if.valid <= 1'b0;
    pix_if.red   <= '0;
    pix_if.green <= '0;
    pix_if.blue  <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Threshold and extreme pixels in one small frame
    set_size(6, 3);
    foreach (probe_pixels[i]) send_pixel(probe_pixels[i]);

    // Zero registers read as one: single-pixel frame
    run_frame(0, 0);

    // Shrink the width mid-frame past the current column
    wait_idle();
    set_size(10, 10);
    send_pixels(37);
    wait_idle();
    set_size(4, 10);
    frame_remaining(n);
    send_pixels(n);

    // Column skip count beyond the new step wraps to zero
    wait_idle();
    set_size(256, 1);
    send_pixels(3);
    wait_idle();
    set_size(65, 1);
    frame_remaining(n);
    send_pixels(n);

    // Largest sizes, cut short: clamped width, clamped height, sampled rows
    run_partial(8191, 1, 100);
    run_partial(1, 5000, 100);
    run_partial(66, 130, 133);

    // Hold off the receiver while one-pixel frames keep coming
    wait_idle();
    set_size(1, 1);
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    send_pixels(12);

    // Random frames under changing idle and stall patterns
    random_pixels = 0;
    random_frames = 0;
    while (random_pixels < 250 || random_frames < 16) begin
      case ((random_frames / 4) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      if (random_frames == 0 || $urandom_range(0, 1)) begin
        wait_idle();
        random_size();
      end
      frame_remaining(n);
      // now and then resize partway through the frame
      if ($urandom_range(0, 4) == 0 && n > 1) begin
        part = $urandom_range(1, n - 1);
        send_pixels(part);
        random_pixels += part;
        wait_idle();
        random_size();
        frame_remaining(n);
      end
      send_pixels(n);
      random_pixels += n;
      random_frames++;
    end

    // Drain and settle
    pix_if.valid <= 1'b0;
    @(negedge clk_i);
    while (scores_due != 0) @(negedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
